@@ sv/csfp_pkg.sv @@
// Shared types, widths and constants for the four-point circumsphere pipeline.
// Used by every module of the block; depends on nothing.
package csfp_pkg;

  localparam int COORD_W = 32;               // coordinate width, signed Q16.16
  localparam int FRAC_W  = 16;               // fraction bits
  localparam int NFIELD  = 12;               // coordinates in one request
  localparam int IN_W    = NFIELD * COORD_W; // request payload
  localparam int ST_LSB  = 4 * COORD_W;      // status position in the result
  localparam int OUT_W   = ((ST_LSB + 2 + 7) / 8) * 8;

  localparam int VW  = COORD_W + 1;          // edge vector component
  localparam int PPW = 2 * VW;               // product of two components
  localparam int KW  = PPW + 1;              // cross product / squared length
  localparam int MW  = KW;                   // wide multiplier operand
  localparam int MH  = (MW - 1) / 2;         // limb width of the wide multiplier
  localparam int PW  = 2 * MW;               // wide multiplier product
  localparam int SW  = PW + 2;               // sum of three wide products
  localparam int DW  = SW;                   // divider datapath
  localparam int QB  = COORD_W + 2;          // quotient bits kept exactly
  localparam int RW  = 2 * COORD_W + 3;      // sum of squared offsets
  localparam int RB  = COORD_W + 1;          // integer square root bits

  localparam logic [COORD_W-1:0] TH_RESET = COORD_W'(1);
  localparam logic [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Cyclic neighbors of an axis or edge index
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_COLL  = 2'd1,
    ST_DEGEN = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] pa;   // first point
    logic [2:0]              neg;  // offset sign per axis
    status_t                 st;   // early status
  } div_side_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] cen;  // clamped center
    logic                    csat; // a center clamp acted
    logic                    rsat; // radius known to saturate
    status_t                 st;   // early status
  } sqrt_side_t;

endpackage

@@ sv/csfp_mul.sv @@
// Two-stage signed multiplier for wide operands, built from four limb products.
// Depends on csfp_pkg.
module csfp_mul (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [csfp_pkg::MW-1:0] a,
  input  logic signed [csfp_pkg::MW-1:0] b,
  output logic signed [csfp_pkg::PW-1:0] p
);
  import csfp_pkg::*;

  logic [MW-1:0]   am, bm;
  logic [2*MH-1:0] pp0, pp1, pp2, pp3;
  logic            sgn;
  logic [PW-1:0]   mag;

  // Take magnitudes
  assign am = a[MW-1] ? MW'(-a) : MW'(a);
  assign bm = b[MW-1] ? MW'(-b) : MW'(b);

  // Form limb products
  always_ff @(posedge clk) begin
    if (en) begin
      pp0 <= am[MH-1:0] * bm[MH-1:0];
      pp1 <= am[2*MH-1:MH] * bm[MH-1:0];
      pp2 <= am[MH-1:0] * bm[2*MH-1:MH];
      pp3 <= am[2*MH-1:MH] * bm[2*MH-1:MH];
      sgn <= a[MW-1] ^ b[MW-1];
    end
  end

  assign mag = PW'(pp0) + (PW'(pp1) << MH) + (PW'(pp2) << MH) + (PW'(pp3) << (2 * MH));

  // Combine and restore sign
  always_ff @(posedge clk) begin
    if (en) begin
      p <= sgn ? -signed'(mag) : signed'(mag);
    end
  end

endmodule

@@ sv/csfp_div.sv @@
// Pipelined restoring divider for the three center offsets, one quotient bit per stage.
// Depends on csfp_pkg.
module csfp_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [2:0][csfp_pkg::DW-1:0]       nabs,
  input  logic [csfp_pkg::DW-1:0]            dvs,
  input  csfp_pkg::div_side_t                side_in,
  output logic                               out_valid,
  output logic [2:0][csfp_pkg::QB-1:0]       q_out,
  output logic [2:0]                         big_out,
  output csfp_pkg::div_side_t                side_out
);
  import csfp_pkg::*;

  logic                  vld [0:QB];
  logic [2:0][DW-1:0]    rem [0:QB];
  logic [2:0][QB-1:0]    qr  [0:QB];
  logic [DW-1:0]         dv  [0:QB];
  logic [2:0]            bg  [0:QB];
  div_side_t             sd  [0:QB];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k <= QB; k++) vld[k] <= vld[k-1];
    end
  end

  // Load, flag quotients too large to keep, then one bit per stage
  always_ff @(posedge clk) begin
    logic [DW-1:0] dsh;
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        rem[0][j] <= nabs[j];
        bg[0][j]  <= nabs[j] >= (dvs << QB);
        qr[0][j]  <= '0;
      end
      dv[0] <= dvs;
      sd[0] <= side_in;
      for (int k = 1; k <= QB; k++) begin
        dsh = dv[k-1] << (QB - k);
        for (int j = 0; j < 3; j++) begin
          if (rem[k-1][j] >= dsh) begin
            rem[k][j] <= rem[k-1][j] - dsh;
            qr[k][j]  <= qr[k-1][j] | (QB'(1) << (QB - k));
          end else begin
            rem[k][j] <= rem[k-1][j];
            qr[k][j]  <= qr[k-1][j];
          end
        end
        dv[k] <= dv[k-1];
        bg[k] <= bg[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  assign out_valid = vld[QB];
  assign q_out     = qr[QB];
  assign big_out   = bg[QB];
  assign side_out  = sd[QB];

endmodule

@@ sv/csfp_sqrt.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage, with remainder.
// Depends on csfp_pkg.
module csfp_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [csfp_pkg::RW-1:0]   s_in,
  input  csfp_pkg::sqrt_side_t      side_in,
  output logic                      out_valid,
  output logic [csfp_pkg::RB-1:0]   root,
  output logic [csfp_pkg::RW-1:0]   rem_out,
  output csfp_pkg::sqrt_side_t      side_out
);
  import csfp_pkg::*;

  logic          vld [0:RB];
  logic [RW-1:0] rm  [0:RB];
  logic [RB-1:0] rt  [0:RB];
  sqrt_side_t    sd  [0:RB];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= RB; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k <= RB; k++) vld[k] <= vld[k-1];
    end
  end

  // Try each root bit from the top, keep it if the trial fits the remainder
  always_ff @(posedge clk) begin
    logic [RW-1:0] trial;
    if (en) begin
      rm[0] <= s_in;
      rt[0] <= '0;
      sd[0] <= side_in;
      for (int k = 1; k <= RB; k++) begin
        trial = (RW'(rt[k-1]) << (RB - k + 1)) | (RW'(1) << (2 * (RB - k)));
        if (rm[k-1] >= trial) begin
          rm[k] <= rm[k-1] - trial;
          rt[k] <= rt[k-1] | (RB'(1) << (RB - k));
        end else begin
          rm[k] <= rm[k-1];
          rt[k] <= rt[k-1];
        end
        sd[k] <= sd[k-1];
      end
    end
  end

  assign out_valid = vld[RB];
  assign root      = rt[RB];
  assign rem_out   = rm[RB];
  assign side_out  = sd[RB];

endmodule

@@ sv/circumsphere_from_four_points_top.sv @@
// Circumsphere of four points: top level with edge, cross, determinant and post stages.
// Depends on csfp_pkg, csfp_mul, csfp_div and csfp_sqrt.
//
// Usage: each request on the s_ group carries four points A, B, C, D in signed
// Q16.16. One result per request leaves on the m_ group: the sphere center, its
// radius and a status (ok, collinear first three points, degenerate determinant,
// saturated). Non-ok status other than saturation zeroes center and radius.
// cfg_wen/cfg_wdata write the determinant threshold; write it only while idle.
// A request passes 8 stages of edge vectors, cross products, wide two-stage
// multipliers and sums, 35 divider stages (a load stage, then one quotient bit
// each), 2 offset/square stages, 34 square root stages and the output register.
// Throughput is one request per cycle. The whole pipeline advances together while
// the output register is empty or being taken; when the receiver stalls, s_tready
// drops in the same cycle and every stage holds. Reset empties the pipeline and
// sets the threshold to 1.
module circumsphere_from_four_points_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [csfp_pkg::COORD_W-1:0] cfg_wdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // point_a_x, point_a_y, point_a_z, point_b_x .. point_d_z, 32 bits each
  input  logic [csfp_pkg::IN_W-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // center_x, center_y, center_z, sphere_radius (32 bits each), status (2), zero pad
  output logic [csfp_pkg::OUT_W-1:0]   m_tdata
);
  import csfp_pkg::*;

  logic                    en;
  logic [COORD_W-1:0]      thr;
  logic                    vld   [1:8];
  logic [2:0][COORD_W-1:0] pa_d  [1:7];
  logic                    coll_d [4:7];

  logic signed [VW-1:0]    v     [3][3];
  logic signed [VW-1:0]    v0_s2 [3];
  logic signed [VW-1:0]    v0_s3 [3];
  logic                    vnz   [3];
  logic                    vnz_s3 [3];
  logic signed [PPW-1:0]   ppa   [3][3];
  logic signed [PPW-1:0]   ppb   [3][3];
  logic signed [PPW-1:0]   sqp   [3][3];
  logic signed [KW-1:0]    k     [3][3];
  logic signed [KW-1:0]    sq    [3];

  logic signed [PW-1:0]    det_p [3];
  logic signed [PW-1:0]    num_p [3][3];
  logic signed [SW-1:0]    det6;
  logic signed [SW-1:0]    num6  [3];
  logic [SW-1:0]           anum7 [3];
  logic [SW-1:0]           ad7;
  logic                    dz7;
  logic [2:0]              neg7;
  logic [2:0][DW-1:0]      nabs8;
  logic [DW-1:0]           d2_8;
  div_side_t               side8;

  logic                    dv_valid;
  logic [2:0][QB-1:0]      q_o;
  logic [2:0]              big_o;
  div_side_t               dside;

  logic                    p1_valid;
  sqrt_side_t              side_p1, side_p1_next;
  logic [2*COORD_W-1:0]    sqq_p1 [3];
  logic                    p2_valid;
  logic [RW-1:0]           s_p2;
  sqrt_side_t              side_p2;

  logic                    sq_valid;
  logic [RB-1:0]           root;
  logic [RW-1:0]           srem;
  sqrt_side_t              sside;
  logic [OUT_W-1:0]        m_tdata_next;

  // Whole pipeline moves when the output register can take a result
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= TH_RESET;
    end else if (cfg_wen) begin
      thr <= cfg_wdata;
    end
  end

  // Valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= 8; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[1] <= s_tvalid;
      for (int s = 2; s <= 8; s++) vld[s] <= vld[s-1];
    end
  end

  // Edge vectors, products, cross products and squared lengths
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pa_d[1][j] <= s_tdata[j*COORD_W +: COORD_W];
        for (int i = 0; i < 3; i++) begin
          v[i][j] <= VW'(signed'(s_tdata[(3*(i+1)+j)*COORD_W +: COORD_W]))
                   - VW'(signed'(s_tdata[j*COORD_W +: COORD_W]));
        end
      end
      for (int s = 2; s <= 7; s++) pa_d[s] <= pa_d[s-1];

      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 3; j++) begin
          ppa[c][j] <= v[NXT[c]][NXT[j]] * v[PRV[c]][PRV[j]];
          ppb[c][j] <= v[NXT[c]][PRV[j]] * v[PRV[c]][NXT[j]];
          sqp[c][j] <= v[c][j] * v[c][j];
        end
        vnz[c]   <= (v[c][0] != '0) || (v[c][1] != '0) || (v[c][2] != '0);
        v0_s2[c] <= v[0][c];
      end

      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 3; j++) begin
          k[c][j] <= KW'(ppa[c][j]) - KW'(ppb[c][j]);
        end
        sq[c]     <= KW'(sqp[c][0]) + KW'(sqp[c][1]) + KW'(sqp[c][2]);
        vnz_s3[c] <= vnz[c];
        v0_s3[c]  <= v0_s2[c];
      end

      coll_d[4] <= vnz_s3[0] && vnz_s3[1] &&
                   (k[2][0] == '0) && (k[2][1] == '0) && (k[2][2] == '0);
      for (int s = 5; s <= 7; s++) coll_d[s] <= coll_d[s-1];
    end
  end

  // Determinant terms and center numerator terms
  for (genvar j = 0; j < 3; j++) begin : g_det
    csfp_mul u_mul (
      .clk (clk),
      .en  (en),
      .a   (MW'(v0_s3[j])),
      .b   (k[0][j]),
      .p   (det_p[j])
    );
    for (genvar i = 0; i < 3; i++) begin : g_num
      csfp_mul u_mul (
        .clk (clk),
        .en  (en),
        .a   (sq[i]),
        .b   (k[i][j]),
        .p   (num_p[i][j])
      );
    end
  end

  // Sum, take magnitudes, then form dividend, divisor and early status
  always_ff @(posedge clk) begin
    if (en) begin
      det6 <= SW'(det_p[0]) + SW'(det_p[1]) + SW'(det_p[2]);
      for (int j = 0; j < 3; j++) begin
        num6[j] <= SW'(num_p[0][j]) + SW'(num_p[1][j]) + SW'(num_p[2][j]);
      end

      ad7 <= det6[SW-1] ? SW'(-det6) : SW'(det6);
      dz7 <= det6 == '0;
      for (int j = 0; j < 3; j++) begin
        anum7[j] <= num6[j][SW-1] ? SW'(-num6[j]) : SW'(num6[j]);
        neg7[j]  <= num6[j][SW-1] ^ det6[SW-1];
      end

      for (int j = 0; j < 3; j++) nabs8[j] <= anum7[j] + ad7;
      d2_8       <= ad7 << 1;
      side8.pa   <= pa_d[7];
      side8.neg  <= neg7;
      if (coll_d[7]) begin
        side8.st <= ST_COLL;
      end else if (dz7 || ((ad7 << 1) < (DW'(thr) << (2 * FRAC_W)))) begin
        side8.st <= ST_DEGEN;
      end else begin
        side8.st <= ST_OK;
      end
    end
  end

  csfp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld[8]),
    .nabs      (nabs8),
    .dvs       (d2_8),
    .side_in   (side8),
    .out_valid (dv_valid),
    .q_out     (q_o),
    .big_out   (big_o),
    .side_out  (dside)
  );

  // Add offsets to the first point and clamp
  always_comb begin
    logic signed [COORD_W+3:0] off;
    logic signed [COORD_W+3:0] cs;
    side_p1_next.st   = dside.st;
    side_p1_next.csat = 1'b0;
    side_p1_next.rsat = 1'b0;
    for (int j = 0; j < 3; j++) begin
      off = dside.neg[j] ? -signed'((COORD_W+4)'(q_o[j])) : signed'((COORD_W+4)'(q_o[j]));
      cs  = (COORD_W+4)'(signed'(dside.pa[j])) + off;
      if (big_o[j]) begin
        side_p1_next.cen[j] = dside.neg[j] ? CMIN : CMAX;
        side_p1_next.csat   = 1'b1;
      end else if (cs[COORD_W+3:COORD_W-1] != {5{cs[COORD_W-1]}}) begin
        side_p1_next.cen[j] = cs[COORD_W+3] ? CMIN : CMAX;
        side_p1_next.csat   = 1'b1;
      end else begin
        side_p1_next.cen[j] = cs[COORD_W-1:0];
      end
      if (big_o[j] || (q_o[j][QB-1:COORD_W] != '0)) side_p1_next.rsat = 1'b1;
    end
  end

  // Valid bits of the post-divide stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= dv_valid;
      p2_valid <= p1_valid;
    end
  end

  // Square the offsets, then sum them
  always_ff @(posedge clk) begin
    if (en) begin
      side_p1 <= side_p1_next;
      for (int j = 0; j < 3; j++) sqq_p1[j] <= q_o[j][COORD_W-1:0] * q_o[j][COORD_W-1:0];
      s_p2    <= RW'(sqq_p1[0]) + RW'(sqq_p1[1]) + RW'(sqq_p1[2]);
      side_p2 <= side_p1;
    end
  end

  csfp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p2_valid),
    .s_in      (s_p2),
    .side_in   (side_p2),
    .out_valid (sq_valid),
    .root      (root),
    .rem_out   (srem),
    .side_out  (sside)
  );

  // Round the root, saturate and pack the result
  always_comb begin
    logic [RB:0]        r_fin;
    logic               radsat;
    logic [COORD_W-1:0] rad;
    r_fin  = {1'b0, root} + (RB+1)'(srem > RW'(root));
    radsat = sside.rsat || (r_fin[RB:COORD_W] != '0);
    rad    = radsat ? {COORD_W{1'b1}} : r_fin[COORD_W-1:0];
    m_tdata_next = '0;
    if (sside.st == ST_COLL || sside.st == ST_DEGEN) begin
      m_tdata_next[ST_LSB +: 2] = sside.st;
    end else begin
      m_tdata_next[0 +: COORD_W]         = sside.cen[0];
      m_tdata_next[COORD_W +: COORD_W]   = sside.cen[1];
      m_tdata_next[2*COORD_W +: COORD_W] = sside.cen[2];
      m_tdata_next[3*COORD_W +: COORD_W] = rad;
      m_tdata_next[ST_LSB +: 2]          = (sside.csat || radsat) ? ST_SAT : ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= m_tdata_next;
    end
  end

  // A collinear or degenerate result carries no center and no radius
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[ST_LSB +: 2] == ST_COLL || m_tdata[ST_LSB +: 2] == ST_DEGEN)
    |-> m_tdata[ST_LSB-1:0] == '0)
    else $error("failed status with nonzero payload");

  // A stall freezes the front of the pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld[8] == $past(vld[8]))
    else $error("front stage moved during stall");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule
